FILE: design/assert_macros.svh
// Assertion helper macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a result in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a result in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/tlb_pkg.sv
// ---------------------------------------------------------------------------
// tlb_pkg
// Shared types and constants of the translation buffer.
// ---------------------------------------------------------------------------
package tlb_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int AGE_BITS_DEF    = 16;
    localparam int PID_W           = 16;
    localparam int PAGE_W          = 20;
    localparam int LIMIT_W         = 5;

    // Register indexes
    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_POLICY  = 1'b1;

    // Operation and policy codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;
    localparam logic POL_FIFO  = 1'b0;
    localparam logic POL_LRU   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture input word
        logic exec;   // update entries, produce result
    } t_cmd;

endpackage

FILE: design/tlb_ctrl.sv
// ---------------------------------------------------------------------------
// tlb_ctrl
// Sequencer: capture a word, execute it, hold the result until taken.
// ---------------------------------------------------------------------------
module tlb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output tlb_pkg::t_cmd o_cmd
);
    import tlb_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                // take a new word while the result is taken
                if (!i_stall) begin
                    o_stall = 1'b0;
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: design/tlb_dp.sv
// ---------------------------------------------------------------------------
// tlb_dp
// Entry array with parallel compare, victim select and compaction.
// ---------------------------------------------------------------------------
module tlb_dp #(
    parameter int MAX_ENTRIES = tlb_pkg::MAX_ENTRIES_DEF,
    parameter int AGE_BITS    = tlb_pkg::AGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlb_pkg::t_cmd               i_cmd,
    input  logic [tlb_pkg::LIMIT_W-1:0] i_limit,
    input  logic                        i_policy,
    input  logic                        i_operation,
    input  logic [tlb_pkg::PID_W-1:0]   i_pid,
    input  logic [tlb_pkg::PAGE_W-1:0]  i_page,
    input  logic [tlb_pkg::PAGE_W-1:0]  i_new_frame,
    output logic                        o_hit,
    output logic [tlb_pkg::PAGE_W-1:0]  o_frame,
    output logic                        o_evicted,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] o_fill
);
    import tlb_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = 1 << IW;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [PID_W-1:0]    r_pid   [MAX_ENTRIES];
    logic [PAGE_W-1:0]   r_page  [MAX_ENTRIES];
    logic [PAGE_W-1:0]   r_frm   [MAX_ENTRIES];
    logic [AGE_BITS-1:0] r_age   [MAX_ENTRIES];
    logic [CW-1:0]       r_fill;
    logic                r_op;
    logic [PID_W-1:0]    r_ipid;
    logic [PAGE_W-1:0]   r_ipage;
    logic [PAGE_W-1:0]   r_inf;
    logic                r_hit, r_ev;
    logic [PAGE_W-1:0]   r_ofrm;

    logic [MAX_ENTRIES-1:0] match;
    logic                   any_hit;
    logic [IW-1:0]          hit_idx;
    logic [IW-1:0]          victim;
    logic [CW-1:0]          lim;
    logic                   do_evict;
    logic [CW-1:0]          fill_after;

    // Compare tree nodes: node n has children 2n+1 and 2n+2, leaves last
    logic                   tree_vld [2*PW-1];
    logic [AGE_BITS-1:0]    tree_age [2*PW-1];
    logic [IW-1:0]          tree_idx [2*PW-1];

    // Capture input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_ipid  <= i_pid;
            r_ipage <= i_page;
            r_inf   <= i_new_frame;
        end
    end

    // Parallel compare, first match wins
    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            match[i] = (CW'(i) < r_fill) && (r_pid[i] == r_ipid) && (r_page[i] == r_ipage);
            if (match[i]) begin
                any_hit = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // Oldest by age: a balanced tree, the right (later) side wins ties
    always_comb begin
        for (int j = 0; j < PW; j++) begin
            tree_vld[PW-1+j] = (j < MAX_ENTRIES) && (CW'(j) < r_fill);
            tree_age[PW-1+j] = (j < MAX_ENTRIES) ? r_age[j % MAX_ENTRIES] : '0;
            tree_idx[PW-1+j] = IW'(j);
        end
        for (int n = PW - 2; n >= 0; n--) begin
            if (tree_vld[2*n+2] &&
                (!tree_vld[2*n+1] || tree_age[2*n+2] >= tree_age[2*n+1])) begin
                tree_vld[n] = 1'b1;
                tree_age[n] = tree_age[2*n+2];
                tree_idx[n] = tree_idx[2*n+2];
            end else begin
                tree_vld[n] = tree_vld[2*n+1];
                tree_age[n] = tree_age[2*n+1];
                tree_idx[n] = tree_idx[2*n+1];
            end
        end
    end

    // Clamp limit and pick victim
    always_comb begin
        if (i_limit == '0) begin
            lim = CW'(1);
        end else if (int'(i_limit) > MAX_ENTRIES) begin
            lim = CW'(MAX_ENTRIES);
        end else begin
            lim = CW'(i_limit);
        end
        do_evict   = (r_fill >= lim);
        victim     = (i_policy == POL_LRU) ? tree_idx[0] : '0;
        fill_after = do_evict ? r_fill - CW'(1) : r_fill;
    end

    // Update entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.exec && r_op == OP_INSERT) begin
            r_fill <= (fill_after < CW'(MAX_ENTRIES)) ? fill_after + CW'(1) : fill_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_op == OP_LOOKUP) begin
                if (any_hit) begin
                    r_age[hit_idx] <= '0;
                end
                r_hit  <= any_hit;
                r_ofrm <= any_hit ? r_frm[hit_idx] : '0;
                r_ev   <= 1'b0;
            end else begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    logic [AGE_BITS-1:0] a;
                    logic                shift;
                    shift = do_evict && IW'(i) >= victim && i < MAX_ENTRIES - 1;
                    if (CW'(i) == fill_after) begin
                        r_pid[i]  <= r_ipid;
                        r_page[i] <= r_ipage;
                        r_frm[i]  <= r_inf;
                        r_age[i]  <= AGE_BITS'(1);
                    end else if (shift) begin
                        a = r_age[(i + 1) % MAX_ENTRIES];
                        r_pid[i]  <= r_pid[(i + 1) % MAX_ENTRIES];
                        r_page[i] <= r_page[(i + 1) % MAX_ENTRIES];
                        r_frm[i]  <= r_frm[(i + 1) % MAX_ENTRIES];
                        r_age[i]  <= (a == AGE_MAX) ? a : a + AGE_BITS'(1);
                    end else begin
                        a = r_age[i];
                        r_age[i] <= (a == AGE_MAX) ? a : a + AGE_BITS'(1);
                    end
                end
                r_hit  <= 1'b0;
                r_ofrm <= '0;
                r_ev   <= do_evict;
            end
        end
    end

    assign o_hit     = r_hit;
    assign o_frame   = r_ofrm;
    assign o_evicted = r_ev;
    assign o_fill    = r_fill;

endmodule

FILE: design/tlb_fifo_lru_lookup_insert.sv
// ---------------------------------------------------------------------------
// tlb_fifo_lru_lookup_insert
// Fully associative TLB with FIFO or LRU replacement.
// ---------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | operation, pid, page, new_frame
// output  | out       | o_valid / i_stall  | hit, frame, evicted
// config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Each word passes through a capture step and an execute step in which
// the compare array, victim select and compaction settle together.
// Reset clears the fill count; entries need no clearing.
// A new word is taken in the cycle its predecessor's result leaves.
`include "assert_macros.svh"

module tlb_fifo_lru_lookup_insert #(
    parameter int MAX_ENTRIES = tlb_pkg::MAX_ENTRIES_DEF,
    parameter int AGE_BITS    = tlb_pkg::AGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tlb_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [tlb_pkg::PID_W-1:0]     i_pid,
    input  logic [tlb_pkg::PAGE_W-1:0]    i_page,
    input  logic [tlb_pkg::PAGE_W-1:0]    i_new_frame,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [tlb_pkg::PAGE_W-1:0]    o_frame,
    output logic                          o_evicted
);
    import tlb_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [LIMIT_W-1:0] r_limit;
    logic               r_policy;
    t_cmd               cmd;
    logic [CW-1:0]      fill;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_W'(16);
            r_policy <= POL_FIFO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENTRIES: r_limit  <= i_cfg_data;
                REG_POLICY:  r_policy <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tlb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    tlb_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AGE_BITS    (AGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_limit     (r_limit),
        .i_policy    (r_policy),
        .i_operation (i_operation),
        .i_pid       (i_pid),
        .i_page      (i_page),
        .i_new_frame (i_new_frame),
        .o_hit       (o_hit),
        .o_frame     (o_frame),
        .o_evicted   (o_evicted),
        .o_fill      (fill)
    );

    `ASSERT_IMPL(a_fill_max, i_clk, i_rst_n, 1'b1, fill <= CW'(MAX_ENTRIES))
    `ASSERT_NEXT(a_load_exec, i_clk, i_rst_n, cmd.load, cmd.exec && !o_valid)
    `ASSERT_NEXT(a_exec_out, i_clk, i_rst_n, cmd.exec, o_valid)
    `ASSERT_IMPL(a_ins_nohit, i_clk, i_rst_n, o_valid && o_evicted, !o_hit)

endmodule

FILE: tb/tlb_fifo_lru_lookup_insert_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tlb_fifo_lru_lookup_insert_tb
// Self-checking bench for the translation buffer: a directed table, then
// random lookup/insert traffic over several limit and policy settings, with
// random idling on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module tlb_fifo_lru_lookup_insert_tb;
    import tlb_pkg::*;

    localparam int SLOTS   = MAX_ENTRIES_DEF;
    localparam int AGE_TOP = (1 << AGE_BITS_DEF) - 1;

    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] frame;
        logic              evicted;
    } t_result;

    typedef struct {
        logic              op;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] nf;
        bit                fixed;   // expected result typed in below
        t_result           res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = REG_ENTRIES;
    logic [LIMIT_W-1:0] i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_operation = OP_LOOKUP;
    logic [PID_W-1:0]  i_pid = '0;
    logic [PAGE_W-1:0] i_page = '0;
    logic [PAGE_W-1:0] i_new_frame = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_hit;
    logic [PAGE_W-1:0] o_frame;
    logic              o_evicted;

    tlb_fifo_lru_lookup_insert uut (.*);

    // Shadow TLB state
    logic [PID_W-1:0]  sh_pid [SLOTS];
    logic [PAGE_W-1:0] sh_page [SLOTS];
    logic [PAGE_W-1:0] sh_frame [SLOTS];
    int unsigned       sh_age [SLOTS];
    int unsigned       sh_fill;
    int unsigned       sh_limit;
    logic              sh_policy;

    t_result pending_results[$];
    int      error_count = 0;
    int      send_idle = 0;
    int      recv_stall = 0;
    int      hold_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        error_count++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // Compute the result of one word and advance the shadow state
    function automatic t_result tlb_apply(input logic op, input logic [PID_W-1:0] pid,
                                          input logic [PAGE_W-1:0] page,
                                          input logic [PAGE_W-1:0] nf);
        t_result r;
        int unsigned lim, victim;
        r = '0;
        if (op == OP_LOOKUP) begin
            for (int i = 0; i < sh_fill; i++) begin
                if (sh_pid[i] == pid && sh_page[i] == page) begin
                    r.hit = 1'b1;
                    r.frame = sh_frame[i];
                    sh_age[i] = 0;
                    break;
                end
            end
        end else begin
            lim = (sh_limit < 1) ? 1 : (sh_limit > SLOTS ? SLOTS : sh_limit);
            if (sh_fill >= lim) begin
                victim = 0;
                if (sh_policy == POL_LRU) begin
                    for (int i = 1; i < sh_fill; i++)
                        if (!(sh_age[victim] > sh_age[i])) victim = i;
                end
                for (int i = victim; i + 1 < sh_fill; i++) begin
                    sh_pid[i] = sh_pid[i+1];
                    sh_page[i] = sh_page[i+1];
                    sh_frame[i] = sh_frame[i+1];
                    sh_age[i] = sh_age[i+1];
                end
                sh_fill--;
                r.evicted = 1'b1;
            end
            sh_pid[sh_fill] = pid;
            sh_page[sh_fill] = page;
            sh_frame[sh_fill] = nf;
            sh_age[sh_fill] = 0;
            sh_fill++;
            for (int i = 0; i < sh_fill; i++)
                if (sh_age[i] < AGE_TOP) sh_age[i]++;
        end
        return r;
    endfunction

    // Offer one word, honoring the sender idle rate, and wait for acceptance
    task automatic send_word(input logic op, input logic [PID_W-1:0] pid,
                             input logic [PAGE_W-1:0] page, input logic [PAGE_W-1:0] nf,
                             input bit fixed, input t_result want);
        t_result r;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_pid <= pid;
        i_page <= page;
        i_new_frame <= nf;
        do @(posedge i_clk); while (o_stall);
        r = tlb_apply(op, pid, page, nf);
        if (fixed && r != want) report("table row", 32'(r), 32'(want));
        pending_results.push_back(r);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ENTRIES) sh_limit = val;
        else sh_policy = val[0];
        @(posedge i_clk);
    endtask

    // Receiver side: random stall, or a counted long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected word", 32'({o_hit, o_frame, o_evicted}), 32'(0));
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) report("hit", 32'(o_hit), 32'(want.hit));
                if (o_frame !== want.frame) report("frame", 32'(o_frame), 32'(want.frame));
                if (o_evicted !== want.evicted)
                    report("evicted", 32'(o_evicted), 32'(want.evicted));
            end
        end
    end

    // Random word: mostly reuse of a small key pool so lookups hit
    task automatic random_word();
        logic [PID_W-1:0] pid;
        logic [PAGE_W-1:0] page;
        int k;
        if ($urandom_range(3) == 0) begin
            pid = PID_W'($urandom);
            page = PAGE_W'($urandom);
        end else begin
            k = $urandom_range(23);
            pid = (k % 3 == 0) ? 16'hFFFF : PID_W'(k);
            page = (k % 4 == 0) ? 20'hFFFFF : PAGE_W'(k * 3);
        end
        send_word($urandom_range(99) < 45 ? OP_INSERT : OP_LOOKUP, pid, page,
                  PAGE_W'($urandom), 1'b0, '0);
    endtask

    t_row dir_rows[$];

    function automatic t_row mk(logic op, logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                                logic [PAGE_W-1:0] nf, bit fixed, t_result res);
        t_row r;
        r.op = op; r.pid = pid; r.page = page; r.nf = nf; r.fixed = fixed; r.res = res;
        return r;
    endfunction

    initial begin
        sh_fill = 0;
        sh_limit = 16;
        sh_policy = POL_FIFO;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty lookup, extremes, duplicates, limit edges
        dir_rows.push_back(mk(OP_LOOKUP, 16'hFFFF, 20'hFFFFF, 0, 1, '0));
        dir_rows.push_back(mk(OP_INSERT, 16'h0000, 20'h00000, 20'hFFFFF, 1, '0));
        dir_rows.push_back(mk(OP_INSERT, 16'hFFFF, 20'hFFFFF, 20'h00000, 1, '0));
        dir_rows.push_back(mk(OP_LOOKUP, 16'h0000, 20'h00000, 0, 1, '{1'b1, 20'hFFFFF, 1'b0}));
        dir_rows.push_back(mk(OP_LOOKUP, 16'hFFFF, 20'hFFFFF, 0, 1, '{1'b1, 20'h00000, 1'b0}));
        dir_rows.push_back(mk(OP_LOOKUP, 16'hFFFF, 20'h00000, 0, 1, '0));
        dir_rows.push_back(mk(OP_INSERT, 16'h0000, 20'h00000, 20'h12345, 1, '0));
        dir_rows.push_back(mk(OP_LOOKUP, 16'h0000, 20'h00000, 0, 1, '{1'b1, 20'hFFFFF, 1'b0}));
        for (int i = 0; i < 14; i++)
            dir_rows.push_back(mk(OP_INSERT, PID_W'(16'h5A5A + i), PAGE_W'(20'hA5A5A + i),
                                  PAGE_W'(20'h100 + i), 0, '0));
        dir_rows.push_back(mk(OP_LOOKUP, 16'h5A5A, 20'hA5A5A, 20'hFFFFF, 0, '0));
        foreach (dir_rows[n])
            send_word(dir_rows[n].op, dir_rows[n].pid, dir_rows[n].page, dir_rows[n].nf,
                      dir_rows[n].fixed, dir_rows[n].res);
        wait_drained();

        // Random phases over settings; limit 0 and above range included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 69; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 69; end
                default: begin send_idle = 28; recv_stall = 28; end
            endcase
            write_reg(REG_POLICY, LIMIT_W'(ph[0] ? POL_LRU : POL_FIFO));
            case (ph)
                0: write_reg(REG_ENTRIES, 5'd1);
                1: write_reg(REG_ENTRIES, 5'd16);
                2: write_reg(REG_ENTRIES, 5'd0);
                3: write_reg(REG_ENTRIES, 5'd31);
                4: write_reg(REG_ENTRIES, 5'd3);
                default: write_reg(REG_ENTRIES, LIMIT_W'($urandom_range(1, 17)));
            endcase
            if (ph == 5) hold_cycles = 120;
            repeat (75) random_word();
            wait_drained();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
